// File: src/tmtw_pkg.sv
// Shared types and constants for the text-mode terminal writer.
// No dependencies; the cursor unit, the top level, the checkers and the testbench refer to it.
`timescale 1ns / 1ps

package tmtw_pkg;

    localparam logic       OP_PUT     = 1'b0;
    localparam logic       OP_READ    = 1'b1;

    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_TAB     = 8'd9;

    localparam logic [7:0]  COLOR_RESET = 8'd7;
    localparam logic [15:0] CLEAR_CELL  = 16'h0720;
    localparam logic [15:0] BLANK_CELL  = 16'h0020;

    // status of one put, cursor unit to control
    typedef struct packed {
        logic written;
        logic scroll;
    } put_flags_t;

    // one result beat
    typedef struct packed {
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_column;
        logic [15:0] cell_data;
        logic        cell_written;
        logic        did_scroll;
    } rsp_item_t;

endpackage

// File: src/tmtw_cmd_if.sv
// Command channel of the terminal writer: valid/ready plus the request fields.
// Depends on nothing.
`timescale 1ns / 1ps

interface tmtw_cmd_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_column;

    modport source (output valid, output opcode, output char_code, output read_row,
                    output read_column, input ready);
    modport sink   (input valid, input opcode, input char_code, input read_row,
                    input read_column, output ready);
endinterface

// File: src/tmtw_res_if.sv
// Result channel of the terminal writer: valid/ready plus the result fields.
// Depends on nothing.
`timescale 1ns / 1ps

interface tmtw_res_if;
    logic        valid;
    logic        ready;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_column;
    logic [15:0] cell_data;
    logic        cell_written;
    logic        did_scroll;

    modport source (output valid, output cursor_row, output cursor_column,
                    output cell_data, output cell_written, output did_scroll,
                    input ready);
    modport sink   (input valid, input cursor_row, input cursor_column,
                    input cell_data, input cell_written, input did_scroll,
                    output ready);
endinterface

// File: src/tmtw_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module tmtw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/tmtw_cursor.sv
// Cursor advance for one put: newline, tab or stored character, with wrap and scroll.
// Depends on tmtw_pkg.
`timescale 1ns / 1ps

module tmtw_cursor #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  logic [$clog2(ROWS)-1:0]    row,
    input  logic [$clog2(COLUMNS)-1:0] col,
    input  logic [7:0]                 char_code,
    output logic [$clog2(ROWS)-1:0]    row_new,
    output logic [$clog2(COLUMNS)-1:0] col_new,
    output tmtw_pkg::put_flags_t       flags
);

    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLUMNS);

    logic          is_nl;
    logic          is_tab;
    logic [CW:0]   col_ext;
    logic [CW:0]   col_adv;
    logic          wrap;
    logic          at_bottom;

    assign is_nl     = (char_code == tmtw_pkg::CH_NEWLINE);
    assign is_tab    = (char_code == tmtw_pkg::CH_TAB);
    assign col_ext   = {1'b0, col};
    // tab goes to the next multiple of four
    assign col_adv   = is_tab ? ((col_ext | (CW+1)'(3)) + (CW+1)'(1))
                              : (col_ext + (CW+1)'(1));
    assign wrap      = is_nl || (col_adv >= (CW+1)'(COLUMNS));
    assign at_bottom = (row == RW'(ROWS - 1));

    always_comb
    begin
        row_new       = row;
        col_new       = col_adv[CW-1:0];
        flags.written = !is_nl && !is_tab;
        flags.scroll  = 1'b0;
        if (wrap)
        begin
            col_new = '0;
            if (at_bottom)
            begin
                flags.scroll = 1'b1;
            end
            else
            begin
                row_new = row + RW'(1);
            end
        end
    end

endmodule

// File: src/text_mode_terminal_writer_unit.sv
// Text-mode terminal writer top level: screen RAM, cursor, scroll and result register.
// Depends on tmtw_pkg, tmtw_cmd_if, tmtw_res_if, tmtw_ram and tmtw_cursor.
`timescale 1ns / 1ps

// Takes one command beat at a time. A put that does not scroll and a cell read each
// pass through the accept state, then the state in which the screen RAM is written
// (put) or its registered read data comes back (read). A put that scrolls then blanks
// the row through the single RAM write port, one cell at a time in ST_FILL; rows are
// never copied, a top-row pointer rotates instead. After reset the block clears the
// screen RAM, one cell per cycle, before the first command is taken; text_color writes
// are taken at any time. A finished result waits in an output register while the next
// command is accepted; if that register is still full, the result is held in ST_DONE.
module text_mode_terminal_writer_unit #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             text_color_we,
    input  logic [7:0]       text_color_wdata,
    tmtw_cmd_if.sink         cmd,
    tmtw_res_if.source       res
);

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int DEPTH = ROWS * COLUMNS;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_EXEC  = 3'd3;
    localparam logic [2:0] ST_FILL  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]          state_reg,     state_next;
    logic [AW-1:0]       sweep_reg,     sweep_next;
    logic [RW-1:0]       top_reg,       top_next;
    logic [RW-1:0]       row_reg,       row_next;
    logic [CW-1:0]       col_reg,       col_next;
    logic [7:0]          color_reg,     color_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          char_reg,      char_next;
    logic                rd_ok_reg,     rd_ok_next;
    tmtw_pkg::rsp_item_t res_reg,       res_next;
    tmtw_pkg::rsp_item_t out_reg,       out_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [15:0]          ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [15:0]          ram_rdata;

    logic [RW-1:0]        adv_row;
    logic [CW-1:0]        adv_col;
    tmtw_pkg::put_flags_t adv_flags;

    logic [RW:0]          cur_sum;
    logic [RW-1:0]        cur_prow;
    logic [AW-1:0]        cur_addr;
    logic [RW:0]          rd_sum;
    logic [RW-1:0]        rd_prow;
    logic                 rd_ok;
    logic [AW-1:0]        fill_addr;

    logic                 finish;
    logic                 out_free;
    tmtw_pkg::rsp_item_t  fin_item;

    tmtw_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tmtw_cursor #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_cursor (
        .row       (row_reg),
        .col       (col_reg),
        .char_code (char_reg),
        .row_new   (adv_row),
        .col_new   (adv_col),
        .flags     (adv_flags)
    );

    // logical row to physical row through the rotating top pointer
    assign cur_sum  = {1'b0, row_reg} + {1'b0, top_reg};
    assign cur_prow = (cur_sum >= (RW+1)'(ROWS)) ? RW'(cur_sum - (RW+1)'(ROWS))
                                                 : RW'(cur_sum);
    assign cur_addr = AW'(cur_prow) * AW'(COLUMNS) + AW'(col_reg);

    assign rd_ok    = (int'(cmd.read_row) < ROWS) && (int'(cmd.read_column) < COLUMNS);
    assign rd_sum   = {1'b0, RW'(cmd.read_row)} + {1'b0, top_reg};
    assign rd_prow  = (rd_sum >= (RW+1)'(ROWS)) ? RW'(rd_sum - (RW+1)'(ROWS))
                                                : RW'(rd_sum);
    // read address goes out in the accept cycle, data is back in the cycle after
    assign ram_raddr = rd_ok ? (AW'(rd_prow) * AW'(COLUMNS) + AW'(CW'(cmd.read_column)))
                             : '0;

    // the row being blanked is the old top row, which becomes the bottom row
    assign fill_addr = AW'(top_reg) * AW'(COLUMNS) + AW'(sweep_reg[CW-1:0]);

    assign out_free  = !out_valid_reg || res.ready;
    assign cmd.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        top_next       = top_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        color_next     = text_color_we ? text_color_wdata : color_reg;
        out_valid_next = out_valid_reg && !res.ready;
        char_next      = char_reg;
        rd_ok_next     = rd_ok_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = sweep_reg;
        ram_wdata      = tmtw_pkg::CLEAR_CELL;
        finish         = 1'b0;
        fin_item       = res_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we     = 1'b1;
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == AW'(DEPTH - 1))
                begin
                    sweep_next = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    char_next  = cmd.char_code;
                    rd_ok_next = rd_ok;
                    state_next = (cmd.opcode == tmtw_pkg::OP_READ) ? ST_READ : ST_EXEC;
                end
            end
            ST_READ:
            begin
                fin_item.cursor_row    = 5'(row_reg);
                fin_item.cursor_column = 7'(col_reg);
                fin_item.cell_data     = rd_ok_reg ? ram_rdata : '0;
                fin_item.cell_written  = 1'b0;
                fin_item.did_scroll    = 1'b0;
                finish                 = 1'b1;
            end
            ST_EXEC:
            begin
                ram_we    = adv_flags.written;
                ram_waddr = cur_addr;
                ram_wdata = {color_reg, char_reg};
                row_next  = adv_row;
                col_next  = adv_col;
                fin_item.cursor_row    = 5'(adv_row);
                fin_item.cursor_column = 7'(adv_col);
                fin_item.cell_data     = adv_flags.written ? {color_reg, char_reg} : '0;
                fin_item.cell_written  = adv_flags.written;
                fin_item.did_scroll    = adv_flags.scroll;
                if (adv_flags.scroll)
                begin
                    res_next   = fin_item;
                    sweep_next = '0;
                    state_next = ST_FILL;
                end
                else
                begin
                    finish = 1'b1;
                end
            end
            ST_FILL:
            begin
                ram_we     = 1'b1;
                ram_waddr  = fill_addr;
                ram_wdata  = tmtw_pkg::BLANK_CELL;
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == AW'(COLUMNS - 1))
                begin
                    sweep_next = '0;
                    top_next   = (top_reg == RW'(ROWS - 1)) ? '0 : top_reg + RW'(1);
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                finish = 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (finish)
        begin
            if (out_free)
            begin
                out_next       = fin_item;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            else
            begin
                res_next   = fin_item;
                state_next = ST_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            sweep_reg     <= '0;
            top_reg       <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            color_reg     <= tmtw_pkg::COLOR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            top_reg       <= top_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            color_reg     <= color_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg  <= char_next;
        rd_ok_reg <= rd_ok_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    assign res.valid         = out_valid_reg;
    assign res.cursor_row    = out_reg.cursor_row;
    assign res.cursor_column = out_reg.cursor_column;
    assign res.cell_data     = out_reg.cell_data;
    assign res.cell_written  = out_reg.cell_written;
    assign res.did_scroll    = out_reg.did_scroll;

endmodule

// File: src/tmtw_checker.sv
// Port-level checks for the terminal writer, bound to the top level.
// Depends on tmtw_pkg and text_mode_terminal_writer_unit.
`timescale 1ns / 1ps

module tmtw_checker #(
    parameter int ROWS = 25
) (
    input logic        clk,
    input logic        rst_n,
    input logic        text_color_we,
    input logic [7:0]  text_color_wdata,
    input logic        cmd_valid,
    input logic        cmd_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [4:0]  res_cursor_row,
    input logic [6:0]  res_cursor_column,
    input logic [15:0] res_cell_data,
    input logic        res_cell_written,
    input logic        res_did_scroll
);

    logic [7:0] color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= tmtw_pkg::COLOR_RESET;
        end
        else if (text_color_we)
        begin
            color_reg <= text_color_wdata;
        end
    end

    // a held result beat keeps its cell data and cursor position
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_cell_data)
            && $stable(res_cursor_row) && $stable(res_cursor_column))
    else $error("result beat changed while stalled");

    // one command at a time: busy right after a command beat
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken while previous one still in work");

    // stored cells carry the current attribute
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_cell_written |-> res_cell_data[15:8] == color_reg)
    else $error("stored cell has wrong attribute");

    // control characters are never stored
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_cell_written |->
            res_cell_data[7:0] != tmtw_pkg::CH_NEWLINE
            && res_cell_data[7:0] != tmtw_pkg::CH_TAB)
    else $error("newline or tab reported as stored");

    // a scroll leaves the cursor at the start of the bottom row
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_did_scroll |->
            res_cursor_row == 5'(ROWS - 1) && res_cursor_column == 7'd0)
    else $error("scroll left cursor off the bottom row start");

endmodule

bind text_mode_terminal_writer_unit tmtw_checker #(
    .ROWS (ROWS)
) u_tmtw_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .text_color_we     (text_color_we),
    .text_color_wdata  (text_color_wdata),
    .cmd_valid         (cmd.valid),
    .cmd_ready         (cmd.ready),
    .res_valid         (res.valid),
    .res_ready         (res.ready),
    .res_cursor_row    (res.cursor_row),
    .res_cursor_column (res.cursor_column),
    .res_cell_data     (res.cell_data),
    .res_cell_written  (res.cell_written),
    .res_did_scroll    (res.did_scroll)
);

// File: dv/tmtw_checker.sv
// Passive checker for the terminal writer: tracks screen, cursor and color on its own,
// predicts one result beat per accepted command and compares in order.
// Depends on tmtw_pkg, tmtw_cmd_if and tmtw_res_if.
`timescale 1ns / 1ps

module tmtw_scoreboard #(
    parameter int ROWS    = 25,
    parameter int COLUMNS = 80
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       color_we,
    input  logic [7:0] color_wdata,
    tmtw_cmd_if        cmd,
    tmtw_res_if        res,
    output int         fail_count,
    output int         pending_count
);

    localparam int TAB_STEP = 4;

    logic [15:0]         screen_mem [ROWS*COLUMNS];
    int                  cur_row;
    int                  cur_col;
    logic [7:0]          attr;
    tmtw_pkg::rsp_item_t predicted_beats [$];
    int                  mismatches = 0;
    int                  outstanding = 0;

    assign fail_count    = mismatches;
    assign pending_count = outstanding;

    // cursor to next row; at the bottom the screen moves up and a blank row comes in
    function automatic logic advance_row();
        int i;
        cur_row++;
        if (cur_row >= ROWS)
        begin
            for (i = 0; i < (ROWS - 1) * COLUMNS; i++)
                screen_mem[i] = screen_mem[i + COLUMNS];
            for (i = (ROWS - 1) * COLUMNS; i < ROWS * COLUMNS; i++)
                screen_mem[i] = tmtw_pkg::BLANK_CELL;
            cur_row = ROWS - 1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic tmtw_pkg::rsp_item_t terminal_step(input logic op,
                                                          input logic [7:0] ch,
                                                          input logic [4:0] rr,
                                                          input logic [6:0] rc);
        tmtw_pkg::rsp_item_t r;
        r = '0;
        if (op == tmtw_pkg::OP_READ)
        begin
            if (int'(rr) < ROWS && int'(rc) < COLUMNS)
                r.cell_data = screen_mem[int'(rr) * COLUMNS + int'(rc)];
        end
        else if (ch == tmtw_pkg::CH_NEWLINE)
        begin
            cur_col = 0;
            r.did_scroll = advance_row();
        end
        else
        begin
            if (ch == tmtw_pkg::CH_TAB)
                cur_col += TAB_STEP - (cur_col % TAB_STEP);
            else
            begin
                r.cell_data = {attr, ch};
                screen_mem[cur_row * COLUMNS + cur_col] = r.cell_data;
                r.cell_written = 1'b1;
                cur_col++;
            end
            if (cur_col >= COLUMNS)
            begin
                cur_col = 0;
                r.did_scroll = advance_row();
            end
        end
        r.cursor_row    = cur_row[4:0];
        r.cursor_column = cur_col[6:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tmtw_pkg::rsp_item_t seen;
        tmtw_pkg::rsp_item_t want;
        int                  i;
        if (!rst_n)
        begin
            for (i = 0; i < ROWS * COLUMNS; i++)
                screen_mem[i] = tmtw_pkg::CLEAR_CELL;
            cur_row = 0;
            cur_col = 0;
            attr = tmtw_pkg::COLOR_RESET;
            predicted_beats.delete();
            outstanding = 0;
        end
        else
        begin
            if (color_we)
                attr = color_wdata;
            if (cmd.valid && cmd.ready)
                predicted_beats.push_back(terminal_step(cmd.opcode, cmd.char_code,
                                                        cmd.read_row, cmd.read_column));
            if (res.valid && res.ready)
            begin
                seen = {res.cursor_row, res.cursor_column, res.cell_data,
                        res.cell_written, res.did_scroll};
                if (predicted_beats.size() == 0)
                begin
                    if (mismatches < 10)
                        $display({"%0t: result beat with nothing expected: ",
                                  "row %0d col %0d data %h wr %b scr %b"},
                                 $realtime, seen.cursor_row, seen.cursor_column,
                                 seen.cell_data, seen.cell_written, seen.did_scroll);
                    mismatches++;
                end
                else
                begin
                    want = predicted_beats.pop_front();
                    if (seen !== want)
                    begin
                        if (mismatches < 10)
                            $display({"%0t: mismatch exp row %0d col %0d data %h ",
                                      "wr %b scr %b, got row %0d col %0d data %h ",
                                      "wr %b scr %b"},
                                     $realtime, want.cursor_row, want.cursor_column,
                                     want.cell_data, want.cell_written, want.did_scroll,
                                     seen.cursor_row, seen.cursor_column, seen.cell_data,
                                     seen.cell_written, seen.did_scroll);
                        mismatches++;
                    end
                end
            end
            outstanding = predicted_beats.size();
        end
    end

endmodule

// File: dv/tb_text_mode_terminal_writer_unit.sv
// Testbench top for the terminal writer: clock, reset, command and color stimulus,
// result back-pressure and the verdict. Depends on tmtw_pkg, the channel interfaces,
// text_mode_terminal_writer_unit and tmtw_scoreboard.
`timescale 1ns / 1ps

module tb_text_mode_terminal_writer_unit;

    localparam int ROWS            = 25;
    localparam int COLUMNS         = 80;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEMS_PER_PHASE = 210;
    localparam int HOLD_CYCLES     = 300;

    logic       clk;
    logic       rst_n;
    logic       color_we;
    logic [7:0] color_wdata;
    int         fail_count;
    int         pending_count;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         hold_requests;
    int         beats_sent;

    tmtw_cmd_if cmd_ch ();
    tmtw_res_if res_ch ();

    text_mode_terminal_writer_unit #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .text_color_we    (color_we),
        .text_color_wdata (color_wdata),
        .cmd              (cmd_ch),
        .res              (res_ch)
    );

    tmtw_scoreboard #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) screen_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .color_we      (color_we),
        .color_wdata   (color_wdata),
        .cmd           (cmd_ch),
        .res           (res_ch),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("FAILED: results differ");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        int hold_left;
        int holds_done;
        hold_left = 0;
        holds_done = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_done != hold_requests)
            begin
                holds_done = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_beat(input logic op, input logic [7:0] ch,
                             input logic [4:0] rr, input logic [6:0] rc);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.opcode      <= op;
        cmd_ch.char_code   <= ch;
        cmd_ch.read_row    <= rr;
        cmd_ch.read_column <= rc;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic put_char(input logic [7:0] ch);
        send_beat(tmtw_pkg::OP_PUT, ch, 5'($urandom()), 7'($urandom()));
    endtask

    task automatic read_cell(input int rr, input int rc);
        send_beat(tmtw_pkg::OP_READ, 8'($urandom()), 5'(rr), 7'(rc));
    endtask

    // drain all results, let a scroll finish, then load a new color
    task automatic settle_color(input logic [7:0] c);
        cmd_ch.valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (COLUMNS + 8) @(negedge clk);
        color_we    <= 1'b1;
        color_wdata <= c;
        @(negedge clk);
        color_we    <= 1'b0;
    endtask

    task automatic random_phase(input int count);
        int target;
        int kind;
        int len;
        int k;
        int rr;
        int rc;
        target = beats_sent + count;
        while (beats_sent < target)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 50)
            begin
                // a line of text, mostly short, sometimes running past the right edge
                len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 12)
                                                 : $urandom_range(60, 85);
                for (k = 0; k < len; k++)
                begin
                    if ($urandom_range(0, 99) < 8)
                        put_char(tmtw_pkg::CH_TAB);
                    else
                        put_char(8'($urandom_range(0, 255)));
                end
                if ($urandom_range(0, 9) < 7)
                    put_char(tmtw_pkg::CH_NEWLINE);
            end
            else if (kind < 62)
            begin
                len = $urandom_range(1, 30);
                for (k = 0; k < len; k++)
                    put_char(tmtw_pkg::CH_NEWLINE);
            end
            else if (kind < 72)
            begin
                len = $urandom_range(1, 25);
                for (k = 0; k < len; k++)
                    put_char(tmtw_pkg::CH_TAB);
            end
            else if (kind < 92)
            begin
                // reads lean toward the bottom rows where the cursor ends up
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++)
                begin
                    if ($urandom_range(0, 3) == 0)
                        rr = $urandom_range(0, 31);
                    else if ($urandom_range(0, 1) == 1)
                        rr = ROWS - 1 - $urandom_range(0, 2);
                    else
                        rr = $urandom_range(0, ROWS - 1);
                    rc = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                     : $urandom_range(0, COLUMNS - 1);
                    read_cell(rr, rc);
                end
            end
            else
            begin
                len = $urandom_range(1, 5);
                for (k = 0; k < len; k++)
                    send_beat(1'($urandom()), 8'($urandom()), 5'($urandom()),
                              7'($urandom()));
            end
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        color_we           = 1'b0;
        color_wdata        = 8'd0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.opcode      = tmtw_pkg::OP_PUT;
        cmd_ch.char_code   = 8'd0;
        cmd_ch.read_row    = 5'd0;
        cmd_ch.read_column = 7'd0;
        send_idle_pct      = 0;
        recv_idle_pct      = 0;
        hold_requests      = 0;
        beats_sent         = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // cleared screen, corners and out-of-range reads
        read_cell(0, 0);
        read_cell(ROWS - 1, COLUMNS - 1);
        read_cell(ROWS, 0);
        read_cell(0, COLUMNS);
        read_cell(31, 127);
        // characters with the reset color, byte extremes
        put_char(8'h41);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(8'h7F);
        put_char(8'h80);
        put_char(8'h20);
        put_char(tmtw_pkg::CH_TAB);
        put_char(tmtw_pkg::CH_TAB);
        put_char(tmtw_pkg::CH_NEWLINE);
        put_char(tmtw_pkg::CH_TAB);
        put_char(8'h5A);
        read_cell(0, 0);
        read_cell(0, 2);
        read_cell(1, 4);
        read_cell(1, 5);

        settle_color(8'hFF);
        send_idle_pct = 37;
        recv_idle_pct = 69;
        random_phase(ITEMS_PER_PHASE);

        settle_color(8'h00);
        send_idle_pct = 69;
        recv_idle_pct = 37;
        random_phase(ITEMS_PER_PHASE);

        settle_color(8'h1E);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests++;
        random_phase(ITEMS_PER_PHASE);

        cmd_ch.valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (COLUMNS + 20) @(negedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
